// ===== src/skt_pkg.sv =====
// Shared types, S-box and round-constant table for the SKINNY-128-384 round pipeline.
package skt_pkg;

    localparam int SKT_NUM_ROUNDS = 40;
    localparam int SKT_IDX_W      = 6;

    typedef logic [0:15][7:0] skt_blk_t;
    typedef logic [0:63][SKT_IDX_W-1:0] skt_rc_lut_t;

    typedef struct packed {
        logic [63:0]          state_hi;
        logic [63:0]          state_lo;
        logic [63:0]          tk1_hi;
        logic [63:0]          tk1_lo;
        logic [63:0]          tk2_hi;
        logic [63:0]          tk2_lo;
        logic [63:0]          tk3_hi;
        logic [63:0]          tk3_lo;
        logic [SKT_IDX_W-1:0] round_index;
    } skt_in_t;

    typedef struct packed {
        logic [63:0] next_state_hi;
        logic [63:0] next_state_lo;
        logic [63:0] next_tk1_hi;
        logic [63:0] next_tk1_lo;
        logic [63:0] next_tk2_hi;
        logic [63:0] next_tk2_lo;
        logic [63:0] next_tk3_hi;
        logic [63:0] next_tk3_lo;
    } skt_out_t;

    typedef struct packed {
        skt_blk_t state;
        skt_blk_t tk1;
        skt_blk_t tk2;
        skt_blk_t tk3;
    } skt_mid_t;

    localparam logic [0:15][3:0] TK_PERM = '{
        4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11,
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h65,8'h4c,8'h6a,8'h42,8'h4b,8'h63,8'h43,8'h6b,8'h55,8'h75,8'h5a,8'h7a,8'h53,8'h73,8'h5b,8'h7b,
        8'h35,8'h8c,8'h3a,8'h81,8'h89,8'h33,8'h80,8'h3b,8'h95,8'h25,8'h98,8'h2a,8'h90,8'h23,8'h99,8'h2b,
        8'he5,8'hcc,8'he8,8'hc1,8'hc9,8'he0,8'hc0,8'he9,8'hd5,8'hf5,8'hd8,8'hf8,8'hd0,8'hf0,8'hd9,8'hf9,
        8'ha5,8'h1c,8'ha8,8'h12,8'h1b,8'ha0,8'h13,8'ha9,8'h05,8'hb5,8'h0a,8'hb8,8'h03,8'hb0,8'h0b,8'hb9,
        8'h32,8'h88,8'h3c,8'h85,8'h8d,8'h34,8'h84,8'h3d,8'h91,8'h22,8'h9c,8'h2c,8'h94,8'h24,8'h9d,8'h2d,
        8'h62,8'h4a,8'h6c,8'h45,8'h4d,8'h64,8'h44,8'h6d,8'h52,8'h72,8'h5c,8'h7c,8'h54,8'h74,8'h5d,8'h7d,
        8'ha1,8'h1a,8'hac,8'h15,8'h1d,8'ha4,8'h14,8'had,8'h02,8'hb1,8'h0c,8'hbc,8'h04,8'hb4,8'h0d,8'hbd,
        8'he1,8'hc8,8'hec,8'hc5,8'hcd,8'he4,8'hc4,8'hed,8'hd1,8'hf1,8'hdc,8'hfc,8'hd4,8'hf4,8'hdd,8'hfd,
        8'h36,8'h8e,8'h38,8'h82,8'h8b,8'h30,8'h83,8'h39,8'h96,8'h26,8'h9a,8'h28,8'h93,8'h20,8'h9b,8'h29,
        8'h66,8'h4e,8'h68,8'h41,8'h49,8'h60,8'h40,8'h69,8'h56,8'h76,8'h58,8'h78,8'h50,8'h70,8'h59,8'h79,
        8'ha6,8'h1e,8'haa,8'h11,8'h19,8'ha3,8'h10,8'hab,8'h06,8'hb6,8'h08,8'hba,8'h00,8'hb3,8'h09,8'hbb,
        8'he6,8'hce,8'hea,8'hc2,8'hcb,8'he3,8'hc3,8'heb,8'hd6,8'hf6,8'hda,8'hfa,8'hd3,8'hf3,8'hdb,8'hfb,
        8'h31,8'h8a,8'h3e,8'h86,8'h8f,8'h37,8'h87,8'h3f,8'h92,8'h21,8'h9e,8'h2e,8'h97,8'h27,8'h9f,8'h2f,
        8'h61,8'h48,8'h6e,8'h46,8'h4f,8'h67,8'h47,8'h6f,8'h51,8'h71,8'h5e,8'h7e,8'h57,8'h77,8'h5f,8'h7f,
        8'ha2,8'h18,8'hae,8'h16,8'h1f,8'ha7,8'h17,8'haf,8'h01,8'hb2,8'h0e,8'hbe,8'h07,8'hb7,8'h0f,8'hbf,
        8'he2,8'hca,8'hee,8'hc6,8'hcf,8'he7,8'hc7,8'hef,8'hd2,8'hf2,8'hde,8'hfe,8'hd7,8'hf7,8'hdf,8'hff
    };

    // 6-bit round-constant LFSR, one entry per index
    function automatic skt_rc_lut_t build_rc_lut();
        skt_rc_lut_t          lut;
        logic [SKT_IDX_W-1:0] rc;
        rc = 6'h01;
        for (int k = 0; k < 64; k++)
        begin
            lut[k] = rc;
            rc = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
        end
        return lut;
    endfunction

    localparam skt_rc_lut_t RC_LUT = build_rc_lut();

endpackage

// ===== src/skt_sub_stage.sv =====
// Pipeline stage 2: S-box layer, constant and tweakey addition, tweakey schedule.
module skt_sub_stage
    import skt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  skt_in_t  in_data,
    output logic     out_valid,
    output skt_mid_t out_data
);

    logic     valid_reg, valid_next;
    skt_mid_t data_reg, data_next;

    always_comb
    begin
        skt_blk_t             s, t1, t2, t3, p1, p2, p3;
        logic [SKT_IDX_W-1:0] rc;
        s  = {in_data.state_hi, in_data.state_lo};
        t1 = {in_data.tk1_hi, in_data.tk1_lo};
        t2 = {in_data.tk2_hi, in_data.tk2_lo};
        t3 = {in_data.tk3_hi, in_data.tk3_lo};
        rc = RC_LUT[in_data.round_index];

        for (int i = 0; i < 16; i++)
        begin
            s[i] = SBOX[s[i]];
        end
        s[0] = s[0] ^ {4'h0, rc[3:0]};
        s[4] = s[4] ^ {6'h00, rc[5:4]};
        s[8] = s[8] ^ 8'h02;
        for (int i = 0; i < 8; i++)
        begin
            s[i] = s[i] ^ t1[i] ^ t2[i] ^ t3[i];
        end

        for (int i = 0; i < 16; i++)
        begin
            p1[i] = t1[TK_PERM[i]];
            p2[i] = t2[TK_PERM[i]];
            p3[i] = t3[TK_PERM[i]];
        end
        for (int i = 0; i < 8; i++)
        begin
            p2[i] = {p2[i][6:0], p2[i][7] ^ p2[i][5]};
            p3[i] = {p3[i][0] ^ p3[i][6], p3[i][7:1]};
        end

        valid_next     = in_valid;
        data_next      = data_reg;
        if (in_valid)
        begin
            data_next.state = s;
            data_next.tk1   = p1;
            data_next.tk2   = p2;
            data_next.tk3   = p3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/skt_mix_stage.sv =====
// Pipeline stage 3: row rotation, column mixing and result register.
module skt_mix_stage
    import skt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  skt_mid_t in_data,
    output logic     out_valid,
    output skt_out_t out_data
);

    logic     valid_reg, valid_next;
    skt_out_t data_reg, data_next;

    always_comb
    begin
        skt_blk_t  sh, m;
        logic [7:0] a0, a1, a2, a3;
        // row i rotates right by i cells
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                sh[4 * i + j] = in_data.state[4 * i + ((j - i) & 3)];
            end
        end
        for (int j = 0; j < 4; j++)
        begin
            a0 = sh[j];
            a1 = sh[4 + j] ^ sh[8 + j];
            a2 = sh[8 + j] ^ a0;
            a3 = sh[12 + j] ^ a2;
            m[j]      = a3;
            m[4 + j]  = a0;
            m[8 + j]  = a1;
            m[12 + j] = a2;
        end

        valid_next = in_valid;
        data_next  = data_reg;
        if (in_valid)
        begin
            {data_next.next_state_hi, data_next.next_state_lo} = m;
            {data_next.next_tk1_hi, data_next.next_tk1_lo}     = in_data.tk1;
            {data_next.next_tk2_hi, data_next.next_tk2_lo}     = in_data.tk2;
            {data_next.next_tk3_hi, data_next.next_tk3_lo}     = in_data.tk3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/skinny_tweakey_round.sv =====
// Top level: three-stage SKINNY-128-384 round pipeline with command-style ports.
//
//  channel   ports                      transfer when
//  --------  -------------------------  ------------------------------
//  command   start, busy, operands      rising edge with start && !busy
//  result    done, result               rising edge ending the done cycle
//
//  One transfer per clock; each result passes through the three register stages
//  in order: input/index saturation, S-box and tweakey layer, then row rotation
//  and column mixing.
//  busy stays low: the pipeline never stalls since results cannot be held off.
//  Reset clears the valid bits only; payload registers are not reset.
module skinny_tweakey_round
    import skt_pkg::*;
#(
    parameter int NUM_ROUNDS = SKT_NUM_ROUNDS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  skt_in_t  operands,
    output logic     done,
    output skt_out_t result
);

    localparam logic [SKT_IDX_W-1:0] LAST_ROUND = SKT_IDX_W'(NUM_ROUNDS - 1);

    logic     s1_valid_reg, s1_valid_next;
    skt_in_t  s1_data_reg, s1_data_next;
    logic     s2_valid;
    skt_mid_t s2_data;

    assign busy = 1'b0;

    always_comb
    begin
        s1_valid_next = start && !busy;
        s1_data_next  = s1_data_reg;
        if (start && !busy)
        begin
            s1_data_next = operands;
            if (operands.round_index > LAST_ROUND)
            begin
                s1_data_next.round_index = LAST_ROUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg <= s1_data_next;
    end

    skt_sub_stage u_sub (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_data   (s1_data_reg),
        .out_valid (s2_valid),
        .out_data  (s2_data)
    );

    skt_mix_stage u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_data   (s2_data),
        .out_valid (done),
        .out_data  (result)
    );

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) |-> done == $past(start, 3))
        else $error("done does not follow start by three cycles");

    a_index_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_data_reg.round_index <= LAST_ROUND)
        else $error("round index not saturated");

    a_tk1_perm_lo: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && done
        |-> result.next_tk1_lo == $past(operands.tk1_hi, 3))
        else $error("permuted TK1 rows 2-3 do not match input rows 0-1");

endmodule
